// ----- design/tsag_pkg.sv -----
// Shared types, constants and register codes of the scatter address generator.
package tsag_pkg;

	localparam int MAX_RANK    = 4;
	localparam int OFFSET_BITS = 48;

	localparam int NUM_DIMS   = 4;
	localparam int DIM_CAP    = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS;
	localparam int DIM_W      = $clog2(NUM_DIMS);
	localparam int RANK_W     = 3;
	localparam int COORD_W    = 16;
	localparam int STRIDE_W   = 32;
	localparam int PROD_W     = COORD_W + STRIDE_W;
	localparam int DATA_W     = 64;
	localparam int IDX_W      = 64;
	localparam int EXTENTS_W  = NUM_DIMS * COORD_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANK        = 3'd0,
		REG_SCATTER_DIM = 3'd1,
		REG_DIM_EXTENT  = 3'd2,
		REG_SRC_EXTENTS = 3'd3,
		REG_STRIDE_A    = 3'd4,
		REG_STRIDE_B    = 3'd5,
		REG_STRIDE_C    = 3'd6,
		REG_STRIDE_D    = 3'd7
	} cfg_reg_e;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [RANK_W-1:0]                   rank;
		logic [DIM_W-1:0]                    scatter_dim;
		logic [COORD_W-1:0]                  dim_extent;
		logic [EXTENTS_W-1:0]                src_extents;
		logic [NUM_DIMS-1:0][STRIDE_W-1:0]   stride;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		rank:        RANK_W'(1),
		scatter_dim: '0,
		dim_extent:  COORD_W'(1),
		src_extents: '0,
		stride:      '0
	};

	// One request after coordinate selection, ahead of the multipliers.
	typedef struct packed {
		logic [DATA_W-1:0]                   data;
		logic                                wr_en;
		logic                                last;
		logic [NUM_DIMS-1:0][COORD_W-1:0]    coef;
	} s1_t;

	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} pipe_ctl_t;

endpackage

// ----- design/tsag_cfg_regs.sv -----
// Configuration register file of the scatter address generator.
module tsag_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [tsag_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsag_pkg::CFG_DATA_W-1:0]  cfg_data,
	output tsag_pkg::cfg_t                   cfg
);
	import tsag_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_RANK:        cfg_q.rank        <= cfg_data[RANK_W-1:0];
				REG_SCATTER_DIM: cfg_q.scatter_dim <= cfg_data[DIM_W-1:0];
				REG_DIM_EXTENT:  cfg_q.dim_extent  <= cfg_data[COORD_W-1:0];
				REG_SRC_EXTENTS: cfg_q.src_extents <= cfg_data[EXTENTS_W-1:0];
				REG_STRIDE_A:    cfg_q.stride[0]   <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_B:    cfg_q.stride[1]   <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_C:    cfg_q.stride[2]   <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_D:    cfg_q.stride[3]   <= cfg_data[STRIDE_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/tsag_coord_gen.sv -----
// Mixed-radix coordinate counter, index check and per-dimension coefficient select.
module tsag_coord_gen (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [tsag_pkg::DATA_W-1:0]   element_value,
	input  logic signed [tsag_pkg::IDX_W-1:0] index_value,
	input  tsag_pkg::cfg_t                cfg,
	output tsag_pkg::s1_t                 req_s1
);
	import tsag_pkg::*;

	coord_t                   coord_q [NUM_DIMS];
	coord_t                   coord_d [NUM_DIMS];
	logic [NUM_DIMS-1:0]      wrap;
	logic [RANK_W-1:0]        act_rank;
	logic                     carry;
	logic                     idx_ok;
	s1_t                      req_d;
	coord_t                   ext_raw [NUM_DIMS];

	always_comb begin
		if (cfg.rank == '0) begin
			act_rank = RANK_W'(1);
		end else if (cfg.rank > RANK_W'(DIM_CAP)) begin
			act_rank = RANK_W'(DIM_CAP);
		end else begin
			act_rank = cfg.rank;
		end
	end

	// A zero extent counts as one; a coordinate whose next value reaches its extent wraps.
	always_comb begin
		for (int k = 0; k < NUM_DIMS; k++) begin
			ext_raw[k] = cfg.src_extents[k*COORD_W +: COORD_W];
			wrap[k] = ((COORD_W+1)'(coord_q[k]) + (COORD_W+1)'(1)) >=
				((ext_raw[k] == '0) ? (COORD_W+1)'(1) : (COORD_W+1)'(ext_raw[k]));
		end
	end

	// Advance the last active dimension first and ripple the carry down.
	always_comb begin
		carry = 1'b1;
		for (int k = NUM_DIMS - 1; k >= 0; k--) begin
			coord_d[k] = coord_q[k];
			if ((RANK_W'(k) < act_rank) && carry) begin
				coord_d[k] = wrap[k] ? '0 : coord_q[k] + COORD_W'(1);
				carry = wrap[k];
			end
		end
	end

	assign idx_ok = !index_value[IDX_W-1] &&
		(index_value[IDX_W-2:COORD_W] == '0) &&
		(index_value[COORD_W-1:0] < cfg.dim_extent);

	always_comb begin
		req_d.data  = element_value;
		req_d.wr_en = idx_ok;
		req_d.last  = carry;
		for (int k = 0; k < NUM_DIMS; k++) begin
			req_d.coef[k] = '0;
			if (idx_ok && (RANK_W'(k) < act_rank)) begin
				req_d.coef[k] = (DIM_W'(k) == cfg.scatter_dim) ?
					index_value[COORD_W-1:0] : coord_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_DIMS; k++) begin
				coord_q[k] <= '0;
			end
		end else if (accept) begin
			coord_q <= coord_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_d;
		end
	end

endmodule

// ----- design/tsag_offset_pipe.sv -----
// Stride multipliers and offset sum feeding the result register.
module tsag_offset_pipe (
	input  logic                              clk,
	input  tsag_pkg::pipe_ctl_t               ctl,
	input  tsag_pkg::s1_t                     req_s1,
	input  tsag_pkg::cfg_t                    cfg,
	output logic                              write_enable,
	output logic [tsag_pkg::OFFSET_BITS-1:0]  write_offset,
	output logic [tsag_pkg::DATA_W-1:0]       write_data,
	output logic                              last_element
);
	import tsag_pkg::*;

	logic [PROD_W-1:0]      prod_s2 [NUM_DIMS];
	logic [DATA_W-1:0]      data_s2;
	logic                   wr_en_s2;
	logic                   last_s2;
	logic [OFFSET_BITS-1:0] sum;
	logic [OFFSET_BITS-1:0] offset_s3;
	logic [DATA_W-1:0]      data_s3;
	logic                   wr_en_s3;
	logic                   last_s3;

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			for (int k = 0; k < NUM_DIMS; k++) begin
				prod_s2[k] <= PROD_W'(req_s1.coef[k]) * PROD_W'(cfg.stride[k]);
			end
			data_s2  <= req_s1.data;
			wr_en_s2 <= req_s1.wr_en;
			last_s2  <= req_s1.last;
		end
	end

	// Sum wraps at the offset width.
	always_comb begin
		sum = '0;
		for (int k = 0; k < NUM_DIMS; k++) begin
			sum = sum + OFFSET_BITS'(prod_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			offset_s3 <= sum;
			data_s3   <= data_s2;
			wr_en_s3  <= wr_en_s2;
			last_s3   <= last_s2;
		end
	end

	assign write_enable = wr_en_s3;
	assign write_offset = offset_s3;
	assign write_data   = data_s3;
	assign last_element = last_s3;

endmodule

// ----- design/tensor_scatter_address_generator.sv -----
// Throughput: one request per cycle unless a held result stalls the pipe; each of the three
// stages (select, multiply, sum) moves on as soon as the stage after it is empty or drains,
// so bubbles close up.
// Reset clears the stage valids, the coordinate counter and the configuration registers;
// data registers are not reset.
module tensor_scatter_address_generator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [tsag_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tsag_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [tsag_pkg::DATA_W-1:0]          element_value,
	input  logic signed [tsag_pkg::IDX_W-1:0]    index_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 write_enable,
	output logic [tsag_pkg::OFFSET_BITS-1:0]     write_offset,
	output logic [tsag_pkg::DATA_W-1:0]          write_data,
	output logic                                 last_element
);
	import tsag_pkg::*;

	cfg_t      cfg;
	s1_t       req_s1;
	pipe_ctl_t ctl;
	logic      valid_s1;
	logic      valid_s2;
	logic      valid_s3;
	logic      free_s1;
	logic      free_s2;
	logic      free_s3;
	logic      accept;

	assign free_s3 = !valid_s3 || !out_stall;
	assign free_s2 = !valid_s2 || free_s3;
	assign free_s1 = !valid_s1 || free_s2;

	assign in_stall    = !free_s1;
	assign accept      = in_valid && free_s1;
	assign ctl.load_s2 = valid_s1 && free_s2;
	assign ctl.load_s3 = valid_s2 && free_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (free_s1) begin
				valid_s1 <= in_valid;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
			if (free_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	assign out_valid = valid_s3;

	tsag_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tsag_coord_gen u_coord (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.element_value (element_value),
		.index_value   (index_value),
		.cfg           (cfg),
		.req_s1        (req_s1)
	);

	tsag_offset_pipe u_offset (
		.clk          (clk),
		.ctl          (ctl),
		.req_s1       (req_s1),
		.cfg          (cfg),
		.write_enable (write_enable),
		.write_offset (write_offset),
		.write_data   (write_data),
		.last_element (last_element)
	);

endmodule

// ----- design/tsag_checker.sv -----
// Port-level checks of the scatter address generator, bound to the top level.
module tsag_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic                              write_enable,
	input  logic [tsag_pkg::OFFSET_BITS-1:0]  write_offset,
	input  logic [tsag_pkg::DATA_W-1:0]       write_data,
	input  logic                              last_element
);
	import tsag_pkg::*;

	// A held result stays up.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(write_offset) && $stable(write_data) &&
			$stable(write_enable) && $stable(last_element))
		else $error("stalled result changed");

	// Skipped writes carry a zero offset.
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> write_offset == '0)
		else $error("skipped write with nonzero offset");

	// With the result register empty every stage can move, so requests flow in.
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

endmodule

bind tensor_scatter_address_generator tsag_checker u_tsag_checker (.*);

// ----- sim/tensor_scatter_address_generator_test.sv -----
// Self-checking testbench of the scatter write-address generator.
module tensor_scatter_address_generator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tsag_pkg::*;

	typedef struct {
		logic                   wr;
		logic [OFFSET_BITS-1:0] offset;
		logic [DATA_W-1:0]      data;
		logic                   last;
	} scatter_write_t;

	class scatter_scoreboard;
		cfg_t           cfg;
		coord_t         coord [NUM_DIMS];
		scatter_write_t pending_writes [$];
		int unsigned    mismatches, seen, enabled, dropped, passes;

		function new();
			cfg = CFG_RESET;
			foreach (coord[d]) coord[d] = '0;
		endfunction

		function void set_register(cfg_reg_e r, logic [CFG_DATA_W-1:0] v);
			case (r)
				REG_RANK:        cfg.rank        = v[RANK_W-1:0];
				REG_SCATTER_DIM: cfg.scatter_dim = v[DIM_W-1:0];
				REG_DIM_EXTENT:  cfg.dim_extent  = v[COORD_W-1:0];
				REG_SRC_EXTENTS: cfg.src_extents = v[EXTENTS_W-1:0];
				REG_STRIDE_A:    cfg.stride[0]   = v[STRIDE_W-1:0];
				REG_STRIDE_B:    cfg.stride[1]   = v[STRIDE_W-1:0];
				REG_STRIDE_C:    cfg.stride[2]   = v[STRIDE_W-1:0];
				REG_STRIDE_D:    cfg.stride[3]   = v[STRIDE_W-1:0];
			endcase
		endfunction

		// Form the offset of one element, then advance the row-major counter.
		function void note_request(logic [DATA_W-1:0] value, logic [IDX_W-1:0] index);
			scatter_write_t w;
			int             live, d;
			logic [63:0]    sum, term;
			logic [16:0]    extent;
			bit             carry;
			live = (cfg.rank == 0) ? 1 : int'(cfg.rank);
			if (live > DIM_CAP) live = DIM_CAP;
			w.wr = !index[IDX_W-1] && (index < 64'(cfg.dim_extent));
			sum = '0;
			if (w.wr) begin
				for (d = 0; d < live; d++) begin
					term = (d == cfg.scatter_dim) ? index : 64'(coord[d]);
					sum += term * 64'(cfg.stride[d]);
				end
			end
			w.offset = sum[OFFSET_BITS-1:0];
			w.data = value;
			carry = 1'b1;
			// Last active dimension runs fastest; a stale coordinate wraps like extent-1.
			for (d = live - 1; d >= 0 && carry; d--) begin
				extent = 17'(cfg.src_extents[d*COORD_W +: COORD_W]);
				if (extent == 0) extent = 17'd1;
				if (17'(coord[d]) + 17'd1 >= extent) begin
					coord[d] = '0;
				end else begin
					coord[d] = coord[d] + 1'b1;
					carry = 1'b0;
				end
			end
			w.last = carry;
			pending_writes.push_back(w);
		endfunction

		function void report(string field, logic [63:0] want, logic [63:0] got);
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		endfunction

		function void check_write(logic wr, logic [OFFSET_BITS-1:0] offset,
				logic [DATA_W-1:0] data, logic last);
			scatter_write_t w;
			if (pending_writes.size() == 0) begin
				mismatches++;
				$display("%0t: result with no request outstanding, expected none, actual %h %h",
					$time, offset, data);
				return;
			end
			w = pending_writes.pop_front();
			seen++;
			if (w.wr) enabled++;
			else dropped++;
			if (w.last) passes++;
			if (wr !== w.wr) report("write_enable", 64'(w.wr), 64'(wr));
			if (offset !== w.offset) report("write_offset", 64'(w.offset), 64'(offset));
			if (data !== w.data) report("write_data", w.data, data);
			if (last !== w.last) report("last_element", 64'(w.last), 64'(last));
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [DATA_W-1:0]       element_value = '0;
	logic signed [IDX_W-1:0] index_value = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    write_enable;
	logic [OFFSET_BITS-1:0]  write_offset;
	logic [DATA_W-1:0]       write_data;
	logic                    last_element;

	scatter_scoreboard board;
	bit                quiet;
	int unsigned       sent, settings;

	tensor_scatter_address_generator i_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) board.note_request(element_value, index_value);
			if (out_valid && !out_stall)
				board.check_write(write_enable, write_offset, write_data, last_element);
		end
	end

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	initial begin
		int unsigned n;
		forever begin
			n = idle_len();
			out_stall <= (n != 0);
			repeat ((n != 0) ? n : $urandom_range(1, 6)) @(posedge clk);
		end
	end

	task automatic send_request(logic [DATA_W-1:0] value, logic [IDX_W-1:0] index);
		int unsigned gap;
		in_valid <= 1'b1;
		element_value <= value;
		index_value <= index;
		do @(posedge clk); while (in_stall);
		sent++;
		gap = idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off new requests until every expected write has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.pending_writes.size() != 0);
	endtask

	task automatic put_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		board.set_register(r, v);
		@(posedge clk);
	endtask

	// Unused upper data bits carry noise; the block must drop them.
	task automatic load_config(cfg_t c);
		logic [CFG_DATA_W-1:0] junk;
		junk = {$urandom, $urandom};
		put_reg(REG_RANK, {junk[CFG_DATA_W-1:RANK_W], c.rank});
		put_reg(REG_SCATTER_DIM, {junk[CFG_DATA_W-1:DIM_W], c.scatter_dim});
		put_reg(REG_DIM_EXTENT, {junk[CFG_DATA_W-1:COORD_W], c.dim_extent});
		put_reg(REG_SRC_EXTENTS, c.src_extents);
		put_reg(REG_STRIDE_A, {junk[CFG_DATA_W-1:STRIDE_W], c.stride[0]});
		put_reg(REG_STRIDE_B, {junk[CFG_DATA_W-1:STRIDE_W], c.stride[1]});
		put_reg(REG_STRIDE_C, {junk[CFG_DATA_W-1:STRIDE_W], c.stride[2]});
		put_reg(REG_STRIDE_D, {junk[CFG_DATA_W-1:STRIDE_W], c.stride[3]});
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	task automatic send_list(logic [IDX_W-1:0] list [$]);
		foreach (list[i])
			send_request((i % 3 == 0) ? '0 : (i % 3 == 1) ? '1 : {$urandom, $urandom}, list[i]);
		wait_drained();
	endtask

	function automatic cfg_t random_setup();
		cfg_t        c;
		int unsigned r;
		int          d;
		r = $urandom_range(0, 9);
		c.rank = (r < 8) ? RANK_W'($urandom_range(1, DIM_CAP)) : RANK_W'($urandom_range(0, 7));
		c.scatter_dim = DIM_W'($urandom_range(0, NUM_DIMS - 1));
		r = $urandom_range(0, 9);
		c.dim_extent = (r == 0) ? COORD_W'(0) : (r == 1) ? COORD_W'(1) :
			(r == 2) ? {COORD_W{1'b1}} : COORD_W'($urandom_range(2, 300));
		for (d = 0; d < NUM_DIMS; d++) begin
			r = $urandom_range(0, 19);
			c.src_extents[d*COORD_W +: COORD_W] = (r == 0) ? COORD_W'(0) :
				(r == 1) ? {COORD_W{1'b1}} : (r == 2) ? COORD_W'($urandom) :
				COORD_W'($urandom_range(1, 4));
			r = $urandom_range(0, 9);
			c.stride[d] = (r == 0) ? STRIDE_W'(0) : (r == 1) ? {STRIDE_W{1'b1}} :
				STRIDE_W'($urandom);
		end
		return c;
	endfunction

	// Mostly in range, with negatives, values at and past the bound, and raw noise.
	function automatic logic [IDX_W-1:0] pick_index(logic [COORD_W-1:0] bound);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (bound != 0 && r < 70) return IDX_W'($urandom_range(0, bound - 1));
		if (r < 78) return -IDX_W'($urandom_range(1, 16));
		if (r < 86) return IDX_W'(bound) + IDX_W'($urandom_range(0, 3));
		return {$urandom, $urandom};
	endfunction

	initial begin
		cfg_t c;
		int   phase, i, count;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Four dimensions, one zero extent, widest strides so the offset wraps.
		c = CFG_RESET;
		c.rank = RANK_W'(4);
		c.scatter_dim = DIM_W'(1);
		c.dim_extent = {COORD_W{1'b1}};
		c.src_extents = {16'd2, 16'd3, 16'd0, 16'd2};
		c.stride = '1;
		load_config(c);
		send_list('{64'd0, 64'd1, 64'd65534, 64'd65535, '1, 64'h8000_0000_0000_0000,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h1_0000_0000, 64'h1_0000_FFFE, 64'd2, 64'd65533, 64'd0});

		// Rank zero counts as one; a zero bound drops every write.
		c.rank = '0;
		c.dim_extent = '0;
		c.src_extents = 64'd3;
		load_config(c);
		send_list('{64'd0, 64'd1, 64'd5});

		// Rank above the cap saturates.
		c.rank = RANK_W'(7);
		c.scatter_dim = DIM_W'(3);
		c.dim_extent = COORD_W'(9);
		c.src_extents = {16'd3, 16'd1, 16'd2, 16'd1};
		c.stride = {32'd7, 32'h0001_0000, 32'd0, 32'hFFFF_FFFF};
		load_config(c);
		send_list('{64'd8, 64'd9, 64'd3, 64'd0});

		// Scatter dimension outside the rank replaces nothing.
		c.rank = RANK_W'(2);
		c.dim_extent = COORD_W'(5);
		load_config(c);
		send_list('{64'd4, 64'd5, 64'd0, -64'd5});

		for (phase = 0; phase < 12; phase++) begin
			c = random_setup();
			quiet = (phase % 4 == 3);
			load_config(c);
			count = $urandom_range(60, 86);
			for (i = 0; i < count; i++) begin
				if (i == count / 2 && phase % 3 == 1) wait_drained();
				send_request({$urandom, $urandom}, pick_index(c.dim_extent));
			end
			wait_drained();
		end

		quiet = 1'b0;
		wait_drained();
		repeat (12) @(posedge clk);
		$display("Sent %0d requests under %0d register settings; %0d results checked.",
			sent, settings, board.seen);
		$display("%0d writes issued, %0d dropped, %0d complete passes over the source.",
			board.enabled, board.dropped, board.passes);
		if (board.mismatches == 0 && board.pending_writes.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
